// File: hw/rtl/spi_radio_register_sequencer_assert.svh
// Assertion macros shared by the sequencer RTL.
// Each takes a label, the clock, the active-low reset and two expressions.
`ifndef SPI_RADIO_REGISTER_SEQUENCER_ASSERT_SVH
`define SPI_RADIO_REGISTER_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SRSEQ_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("sequencer check failed");
`define SRSEQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("sequencer check failed");
`else
`define SRSEQ_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define SRSEQ_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// File: hw/rtl/srseq_pkg.sv
`default_nettype none

package srseq_pkg;

    localparam int PAYLOAD_BYTES_DEF = 16;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 8;

    localparam logic [7:0] WRITE_BIT = 8'h80;

    // event codes
    localparam logic [2:0] KIND_READ_REG    = 3'd0;
    localparam logic [2:0] KIND_WRITE_REG   = 3'd1;
    localparam logic [2:0] KIND_SEND_PACKET = 3'd2;
    localparam logic [2:0] KIND_RADIO_DONE  = 3'd3;
    localparam logic [2:0] KIND_RX_DONE     = 3'd4;
    localparam logic [2:0] KIND_TX_DONE     = 3'd5;
    localparam logic [2:0] KIND_LOAD_BYTE   = 3'd6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OPMODE_ADDR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_MODE_VALUE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIFO_ADDR     = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_RS_CMD = 4'd1,
        PH_RS_DAT = 4'd2,
        PH_WS_CMD = 4'd3,
        PH_WS_DAT = 4'd4,
        PH_RF_CMD = 4'd5,
        PH_RF_DAT = 4'd6,
        PH_WF_CMD = 4'd7,
        PH_WF_DAT = 4'd8
    } phase_e;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] reg_addr;
        logic [7:0] reg_value;
        logic [7:0] rx_byte;
        logic [5:0] load_index;
        logic [7:0] load_value;
    } req_t;

    typedef struct packed {
        logic       accepted;
        logic       send_valid;
        logic [7:0] send_byte;
        logic       frame_end;
        logic       select_active;
        logic       read_valid;
        logic [7:0] read_data;
        logic       fifo_valid;
        logic [5:0] fifo_index;
        logic [7:0] fifo_data;
        logic       packet_done;
        logic       sent_done;
    } rsp_t;

    typedef struct packed {
        phase_e     phase;
        logic [1:0] join_count;
        logic [6:0] send_count;
        logic [6:0] recv_count;
        logic [7:0] single_byte;
        logic       awaiting_tx_done;
    } state_t;

    typedef struct packed {
        logic [6:0] opmode_addr;
        logic [7:0] rx_mode_value;
        logic [6:0] fifo_addr;
    } cfg_t;

    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } store_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/srseq_ram.sv
`default_nettype none

module srseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/srseq_step.sv
`default_nettype none

module srseq_step #(
    parameter int PAYLOAD_BYTES = srseq_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire srseq_pkg::state_t st,
    input  wire srseq_pkg::req_t   req,
    input  wire srseq_pkg::cfg_t   cfg,
    input  wire logic [7:0]        store_byte,
    output srseq_pkg::state_t      st_next,
    output srseq_pkg::rsp_t        rsp,
    output srseq_pkg::store_wr_t   wr
);

    localparam logic [6:0] PB = 7'(PAYLOAD_BYTES);

    logic       is_idle;
    logic       was_busy;
    logic [1:0] join_inc;
    logic [1:0] join_sum;
    logic       fifo_cmd;
    logic [6:0] cnt;
    logic [6:0] recv_inc;

    always_comb
    begin
        st_next  = st;
        rsp      = '0;
        wr       = '0;
        join_inc = 2'd0;
        fifo_cmd = 1'b0;
        cnt      = st.send_count;
        recv_inc = st.recv_count + 7'd1;
        is_idle  = (st.phase == srseq_pkg::PH_IDLE);
        was_busy = !is_idle;

        case (req.kind)
            srseq_pkg::KIND_READ_REG:
            begin
                if (is_idle)
                begin
                    st_next.phase  = srseq_pkg::PH_RS_CMD;
                    rsp.send_valid = 1'b1;
                    rsp.send_byte  = {1'b0, req.reg_addr};
                    rsp.accepted   = 1'b1;
                end
            end
            srseq_pkg::KIND_WRITE_REG:
            begin
                if (is_idle)
                begin
                    st_next.phase       = srseq_pkg::PH_WS_CMD;
                    st_next.single_byte = req.reg_value;
                    rsp.send_valid      = 1'b1;
                    rsp.send_byte       = srseq_pkg::WRITE_BIT | {1'b0, req.reg_addr};
                    rsp.accepted        = 1'b1;
                end
            end
            srseq_pkg::KIND_SEND_PACKET:
            begin
                if (is_idle)
                begin
                    st_next.awaiting_tx_done = 1'b1;
                    st_next.phase            = srseq_pkg::PH_WF_CMD;
                    rsp.send_valid           = 1'b1;
                    rsp.send_byte            = srseq_pkg::WRITE_BIT | {1'b0, cfg.fifo_addr};
                    rsp.accepted             = 1'b1;
                end
            end
            srseq_pkg::KIND_RADIO_DONE:
            begin
                if (st.awaiting_tx_done)
                begin
                    st_next.awaiting_tx_done = 1'b0;
                    rsp.sent_done            = 1'b1;
                end
                else if (is_idle)
                begin
                    st_next.phase  = srseq_pkg::PH_RF_CMD;
                    rsp.send_valid = 1'b1;
                    rsp.send_byte  = {1'b0, cfg.fifo_addr};
                    rsp.accepted   = 1'b1;
                end
            end
            srseq_pkg::KIND_RX_DONE:
            begin
                case (st.phase)
                    srseq_pkg::PH_IDLE:
                    begin
                    end
                    srseq_pkg::PH_RS_DAT:
                    begin
                        st_next.single_byte = req.rx_byte;
                        join_inc            = 2'd1;
                    end
                    srseq_pkg::PH_WS_DAT:
                    begin
                        join_inc = 2'd1;
                    end
                    srseq_pkg::PH_RF_DAT, srseq_pkg::PH_WF_DAT:
                    begin
                        if (st.recv_count < PB)
                        begin
                            if (st.phase == srseq_pkg::PH_RF_DAT)
                            begin
                                rsp.fifo_valid = 1'b1;
                                rsp.fifo_index = st.recv_count[5:0];
                                rsp.fifo_data  = req.rx_byte;
                            end
                            st_next.recv_count = recv_inc;
                            if (recv_inc == PB)
                            begin
                                join_inc = 2'd1;
                            end
                        end
                    end
                    default:
                    begin
                        // command phases: the address byte has been clocked in
                        join_inc           = 2'd1;
                        st_next.recv_count = 7'd0;
                    end
                endcase
            end
            srseq_pkg::KIND_TX_DONE:
            begin
                case (st.phase)
                    srseq_pkg::PH_RS_CMD:
                    begin
                        rsp.send_valid = 1'b1;
                        rsp.send_byte  = 8'd0;
                        join_inc       = 2'd1;
                    end
                    srseq_pkg::PH_WS_CMD:
                    begin
                        rsp.send_valid = 1'b1;
                        rsp.send_byte  = st.single_byte;
                        join_inc       = 2'd1;
                    end
                    srseq_pkg::PH_RS_DAT, srseq_pkg::PH_WS_DAT:
                    begin
                        join_inc = 2'd1;
                    end
                    srseq_pkg::PH_RF_CMD, srseq_pkg::PH_RF_DAT,
                    srseq_pkg::PH_WF_CMD, srseq_pkg::PH_WF_DAT:
                    begin
                        fifo_cmd = (st.phase == srseq_pkg::PH_RF_CMD)
                                || (st.phase == srseq_pkg::PH_WF_CMD);
                        if (fifo_cmd)
                        begin
                            cnt      = 7'd0;
                            join_inc = 2'd1;
                        end
                        if (cnt >= PB)
                        begin
                            join_inc = join_inc + 2'd1;
                            st_next.send_count = cnt;
                        end
                        else
                        begin
                            rsp.send_valid = 1'b1;
                            if ((st.phase == srseq_pkg::PH_WF_CMD)
                                || (st.phase == srseq_pkg::PH_WF_DAT))
                            begin
                                rsp.send_byte = store_byte;
                            end
                            else
                            begin
                                rsp.send_byte = 8'd0;
                            end
                            st_next.send_count = cnt + 7'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            srseq_pkg::KIND_LOAD_BYTE:
            begin
                if ({1'b0, req.load_index} < PB)
                begin
                    wr.en   = 1'b1;
                    wr.addr = req.load_index;
                    wr.data = req.load_value;
                end
            end
            default:
            begin
            end
        endcase

        join_sum = st.join_count + join_inc;
        st_next.join_count = join_sum;
        if (join_sum == 2'd2)
        begin
            st_next.join_count = 2'd0;
            case (st_next.phase)
                srseq_pkg::PH_IDLE:
                begin
                end
                srseq_pkg::PH_RS_DAT:
                begin
                    st_next.phase  = srseq_pkg::PH_IDLE;
                    rsp.read_valid = 1'b1;
                    rsp.read_data  = st_next.single_byte;
                end
                srseq_pkg::PH_WS_DAT:
                begin
                    st_next.phase = srseq_pkg::PH_IDLE;
                end
                srseq_pkg::PH_RF_DAT:
                begin
                    st_next.phase   = srseq_pkg::PH_IDLE;
                    rsp.packet_done = 1'b1;
                end
                srseq_pkg::PH_WF_DAT:
                begin
                    // close the burst and chain the switch to receive mode
                    rsp.frame_end       = 1'b1;
                    st_next.phase       = srseq_pkg::PH_WS_CMD;
                    st_next.single_byte = cfg.rx_mode_value;
                    rsp.send_valid      = 1'b1;
                    rsp.send_byte       = srseq_pkg::WRITE_BIT | {1'b0, cfg.opmode_addr};
                end
                srseq_pkg::PH_RS_CMD: st_next.phase = srseq_pkg::PH_RS_DAT;
                srseq_pkg::PH_WS_CMD: st_next.phase = srseq_pkg::PH_WS_DAT;
                srseq_pkg::PH_RF_CMD: st_next.phase = srseq_pkg::PH_RF_DAT;
                srseq_pkg::PH_WF_CMD: st_next.phase = srseq_pkg::PH_WF_DAT;
                default:
                begin
                end
            endcase
        end

        if (was_busy && (st_next.phase == srseq_pkg::PH_IDLE))
        begin
            rsp.frame_end = 1'b1;
        end
        rsp.select_active = (st_next.phase != srseq_pkg::PH_IDLE);
    end

endmodule

`default_nettype wire

// File: hw/rtl/spi_radio_register_sequencer.sv
// SPI master sequencer for a packet radio.
//
// Channels: events arrive on req (valid/ready), one beat per event; every
// event yields exactly one result beat on rsp (valid/ready). A separate
// write port (cfg_write, cfg_index, cfg_data) sets the opmode address, the
// receive-mode value and the FIFO address; write it only while idle.
//
// A taken beat waits in the input register and is decoded into the result
// register that drives rsp. Throughput: one event per cycle while rsp is
// not stalled, set by the single decode step between the input register
// and the result register. The outgoing payload store is a RAM with a
// registered read; its read address always follows the next sequencer
// state so the payload byte is ready when a transmit-done arrives, and a
// load to the same entry in the previous cycle is forwarded.
//
// Reset: phase idle, all counters and flags cleared, configuration at its
// defaults. The payload store is not cleared: load it before a send.
// Stall: when rsp_ready is low the result register holds; one more beat
// waits in the input register, after which req_ready drops.
`default_nettype none

module spi_radio_register_sequencer #(
    parameter int PAYLOAD_BYTES = srseq_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire srseq_pkg::req_t                  req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output srseq_pkg::rsp_t                       rsp,
    input  wire logic                             cfg_write,
    input  wire logic [srseq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [srseq_pkg::CFG_DATA_W-1:0]  cfg_data
);

`include "spi_radio_register_sequencer_assert.svh"

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // input stage
    logic              in_vld_reg;
    logic              in_vld_next;
    srseq_pkg::req_t   in_reg;

    // result stage
    logic              out_vld_reg;
    logic              out_vld_next;
    srseq_pkg::rsp_t   out_reg;

    // sequencer state and configuration
    srseq_pkg::state_t state_reg;
    srseq_pkg::state_t state_next;
    srseq_pkg::cfg_t   cfg_reg;

    // payload store forwarding
    logic              byp_hit_reg;
    logic [7:0]        byp_data_reg;

    logic              advance;
    logic              take;
    srseq_pkg::state_t step_state;
    srseq_pkg::rsp_t   step_rsp;
    srseq_pkg::store_wr_t step_wr;
    logic              store_we;
    logic [AW-1:0]     store_raddr;
    logic [7:0]        store_rdata;
    logic [7:0]        store_byte;

    // Advance the decode when the result register is free or being drained.
    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign req_ready = !in_vld_reg || advance;
    assign take      = req_valid && req_ready;

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    srseq_step #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_step (
        .st         (state_reg),
        .req        (in_reg),
        .cfg        (cfg_reg),
        .store_byte (store_byte),
        .st_next    (step_state),
        .rsp        (step_rsp),
        .wr         (step_wr)
    );

    assign state_next = advance ? step_state : state_reg;
    assign store_we   = advance && step_wr.en;

    // Prefetch the entry the next transmit-done will send: entry zero right
    // after the FIFO write command, otherwise the running send count.
    always_comb
    begin
        if (state_next.phase == srseq_pkg::PH_WF_CMD)
        begin
            store_raddr = '0;
        end
        else
        begin
            store_raddr = state_next.send_count[AW-1:0];
        end
    end

    assign store_byte = byp_hit_reg ? byp_data_reg : store_rdata;

    srseq_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (step_wr.addr[AW-1:0]),
        .wdata (step_wr.data),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
            state_reg   <= '{phase: srseq_pkg::PH_IDLE, default: '0};
            cfg_reg     <= '{opmode_addr: 7'd1, rx_mode_value: 8'd16, fifo_addr: 7'd0};
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            state_reg   <= state_next;
            // forward a load that lands on the entry being read this edge
            byp_hit_reg <= store_we && (step_wr.addr[AW-1:0] == store_raddr);
            if (cfg_write)
            begin
                case (cfg_index)
                    srseq_pkg::CFG_OPMODE_ADDR:   cfg_reg.opmode_addr   <= cfg_data[6:0];
                    srseq_pkg::CFG_RX_MODE_VALUE: cfg_reg.rx_mode_value <= cfg_data;
                    srseq_pkg::CFG_FIFO_ADDR:     cfg_reg.fifo_addr     <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_reg <= req;
        end
        if (advance)
        begin
            out_reg <= step_rsp;
        end
        byp_data_reg <= step_wr.data;
    end

    // A taken start leaves the sequencer busy.
    `SRSEQ_ASSERT_IMPLIES(a_accept_busy, clk, rst_n, rsp_valid && rsp.accepted, rsp.select_active)
    // Both threads joined means the count is folded back at once.
    `SRSEQ_ASSERT_IMPLIES(a_join_low, clk, rst_n, 1'b1, !state_reg.join_count[1])
    // A completed read ends the frame and returns to idle.
    `SRSEQ_ASSERT_IMPLIES(a_read_ends, clk, rst_n, rsp_valid && rsp.read_valid,
                          rsp.frame_end && !rsp.select_active)
    // A decoded beat always shows up on the result register next cycle.
    `SRSEQ_ASSERT_NEXT(a_advance_out, clk, rst_n, advance, rsp_valid)

endmodule

`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srseq_pkg::*;

    // Kind 7 has no meaning to the sequencer; it must pass through as a no-op.
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    // Longest run of cycles with no beat on either channel before giving up.
    // The deliberate receiver hold-off is far shorter, so leave plenty of margin.
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_EVENTS    = 250;

    // ------------------------------------------------------------------
    // Sequencer behaviour and result checking
    // ------------------------------------------------------------------
    class radio_seq_scoreboard;
        phase_e      phase;
        logic [1:0]  join_count;
        logic [6:0]  send_count;
        logic [6:0]  recv_count;
        logic [7:0]  single_byte;
        logic        awaiting_tx_done;
        logic [7:0]  payload_store [PAYLOAD_BYTES_DEF];
        cfg_t        regs;
        rsp_t        pending_outcomes [$];
        int unsigned results_checked;
        int unsigned failures;
        int unsigned reads_done;
        int unsigned packets_done;
        int unsigned sends_done;
        int unsigned refused;

        function new();
            phase            = PH_IDLE;
            join_count       = '0;
            send_count       = '0;
            recv_count       = '0;
            single_byte      = '0;
            awaiting_tx_done = 1'b0;
            regs.opmode_addr   = 7'd1;
            regs.rx_mode_value = 8'd16;
            regs.fifo_addr     = 7'd0;
            foreach (payload_store[i])
                payload_store[i] = '0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
            case (idx)
                CFG_OPMODE_ADDR:   regs.opmode_addr   = data[6:0];
                CFG_RX_MODE_VALUE: regs.rx_mode_value = data;
                CFG_FIFO_ADDR:     regs.fifo_addr     = data[6:0];
                default: ;
            endcase
        endfunction

        // Advance the sequencer by one event and return the beat it produces.
        function rsp_t sequence_event(req_t e);
            rsp_t o;
            logic was_busy;
            o = '0;
            was_busy = (phase != PH_IDLE);
            case (e.kind)
                KIND_READ_REG:
                    if (phase == PH_IDLE)
                    begin
                        phase = PH_RS_CMD;
                        o.accepted   = 1'b1;
                        o.send_valid = 1'b1;
                        o.send_byte  = {1'b0, e.reg_addr};
                    end
                KIND_WRITE_REG:
                    if (phase == PH_IDLE)
                    begin
                        phase       = PH_WS_CMD;
                        single_byte = e.reg_value;
                        o.accepted   = 1'b1;
                        o.send_valid = 1'b1;
                        o.send_byte  = {1'b1, e.reg_addr};
                    end
                KIND_SEND_PACKET:
                    if (phase == PH_IDLE)
                    begin
                        awaiting_tx_done = 1'b1;
                        phase = PH_WF_CMD;
                        o.accepted   = 1'b1;
                        o.send_valid = 1'b1;
                        o.send_byte  = {1'b1, regs.fifo_addr};
                    end
                KIND_RADIO_DONE:
                    // a pending send swallows the event; otherwise it starts a FIFO read
                    if (awaiting_tx_done)
                    begin
                        awaiting_tx_done = 1'b0;
                        o.sent_done = 1'b1;
                    end
                    else if (phase == PH_IDLE)
                    begin
                        phase = PH_RF_CMD;
                        o.accepted   = 1'b1;
                        o.send_valid = 1'b1;
                        o.send_byte  = {1'b0, regs.fifo_addr};
                    end
                KIND_RX_DONE:
                    case (phase)
                        PH_IDLE: ;
                        PH_RS_DAT:
                        begin
                            single_byte = e.rx_byte;
                            join_count  = join_count + 2'd1;
                        end
                        PH_WS_DAT:
                            join_count = join_count + 2'd1;
                        PH_RF_DAT, PH_WF_DAT:
                            if (recv_count < PAYLOAD_BYTES_DEF)
                            begin
                                if (phase == PH_RF_DAT)
                                begin
                                    o.fifo_valid = 1'b1;
                                    o.fifo_index = recv_count[5:0];
                                    o.fifo_data  = e.rx_byte;
                                end
                                recv_count = recv_count + 7'd1;
                                if (recv_count == PAYLOAD_BYTES_DEF)
                                    join_count = join_count + 2'd1;
                            end
                        default:
                        begin
                            join_count = join_count + 2'd1;
                            recv_count = '0;
                        end
                    endcase
                KIND_TX_DONE:
                    case (phase)
                        PH_RS_CMD:
                        begin
                            o.send_valid = 1'b1;
                            o.send_byte  = 8'h00;
                            join_count   = join_count + 2'd1;
                        end
                        PH_WS_CMD:
                        begin
                            o.send_valid = 1'b1;
                            o.send_byte  = single_byte;
                            join_count   = join_count + 2'd1;
                        end
                        PH_RS_DAT, PH_WS_DAT:
                            join_count = join_count + 2'd1;
                        PH_RF_CMD, PH_RF_DAT, PH_WF_CMD, PH_WF_DAT:
                        begin
                            if (phase == PH_RF_CMD || phase == PH_WF_CMD)
                            begin
                                send_count = '0;
                                join_count = join_count + 2'd1;
                            end
                            if (send_count >= PAYLOAD_BYTES_DEF)
                                join_count = join_count + 2'd1;
                            else
                            begin
                                o.send_valid = 1'b1;
                                if (phase == PH_WF_CMD || phase == PH_WF_DAT)
                                    o.send_byte = payload_store[send_count % PAYLOAD_BYTES_DEF];
                                else
                                    o.send_byte = 8'h00;
                                send_count = send_count + 7'd1;
                            end
                        end
                        default: ;
                    endcase
                KIND_LOAD_BYTE:
                    if (e.load_index < PAYLOAD_BYTES_DEF)
                        payload_store[e.load_index] = e.load_value;
                default: ;
            endcase

            // both threads have reported: move to the next phase
            if (join_count == 2'd2)
            begin
                join_count = '0;
                case (phase)
                    PH_IDLE: ;
                    PH_RS_DAT:
                    begin
                        phase = PH_IDLE;
                        o.read_valid = 1'b1;
                        o.read_data  = single_byte;
                    end
                    PH_WS_DAT:
                        phase = PH_IDLE;
                    PH_RF_DAT:
                    begin
                        phase = PH_IDLE;
                        o.packet_done = 1'b1;
                    end
                    PH_WF_DAT:
                    begin
                        // close the frame and put the radio back into receive mode
                        o.frame_end  = 1'b1;
                        phase        = PH_WS_CMD;
                        single_byte  = regs.rx_mode_value;
                        o.send_valid = 1'b1;
                        o.send_byte  = {1'b1, regs.opmode_addr};
                    end
                    default:
                        phase = phase_e'(phase + 4'd1);
                endcase
            end

            if (was_busy && phase == PH_IDLE)
                o.frame_end = 1'b1;
            o.select_active = (phase != PH_IDLE);
            return o;
        endfunction

        function void note_event(req_t e);
            rsp_t o;
            o = sequence_event(e);
            if ((e.kind == KIND_READ_REG || e.kind == KIND_WRITE_REG ||
                 e.kind == KIND_SEND_PACKET) && !o.accepted)
                refused++;
            if (o.read_valid)
                reads_done++;
            if (o.packet_done)
                packets_done++;
            if (o.sent_done)
                sends_done++;
            pending_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                failures++;
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_outcomes.size() == 0)
            begin
                failures++;
                $error("result beat arrived with no event outstanding");
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("accepted",      want.accepted,      got.accepted);
            compare_field("send_valid",    want.send_valid,    got.send_valid);
            compare_field("send_byte",     want.send_byte,     got.send_byte);
            compare_field("frame_end",     want.frame_end,     got.frame_end);
            compare_field("select_active", want.select_active, got.select_active);
            compare_field("read_valid",    want.read_valid,    got.read_valid);
            compare_field("read_data",     want.read_data,     got.read_data);
            compare_field("fifo_valid",    want.fifo_valid,    got.fifo_valid);
            compare_field("fifo_index",    want.fifo_index,    got.fifo_index);
            compare_field("fifo_data",     want.fifo_data,     got.fifo_data);
            compare_field("packet_done",   want.packet_done,   got.packet_done);
            compare_field("sent_done",     want.sent_done,     got.sent_done);
            results_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_t                   req       = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // sb checks what the block returns; lookahead tracks the state after every
    // beat already offered, so the stimulus knows which phase it is steering
    radio_seq_scoreboard sb;
    radio_seq_scoreboard lookahead;

    int unsigned beats_sent;
    int unsigned counted_events;
    bit          steady_run;
    bit          hold_request;

    always #2 clk = ~clk;

    spi_radio_register_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Sample both channels at the edge; note each event beat, check each result beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_event(req);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
        end
    end

    // Result side: drop ready at random, except during the steady stretch.
    // On request, hold ready low for a long spell so the block backs up into
    // its input and stalls the sender.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp_ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ready <= steady_run || ($urandom_range(99) >= 31);
        end
    end

    // Watchdog: give up once the run with nothing moving reaches STALL_LIMIT.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("spi_radio_register_sequencer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Fill every field with noise so each bit toggles; callers pin what matters.
    function automatic req_t random_event(logic [2:0] kind);
        req_t e;
        e.kind       = kind;
        e.reg_addr   = 7'($urandom);
        e.reg_value  = 8'($urandom);
        e.rx_byte    = 8'($urandom);
        e.load_index = 6'($urandom);
        e.load_value = 8'($urandom);
        return e;
    endfunction

    // Offer one beat, hold it until taken, then advance the lookahead.
    task automatic offer_event(req_t e);
        while (!steady_run && $urandom_range(99) < 31)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= e;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        beats_sent++;
        // events the block simply ignores do not count towards the run length
        if (!(e.kind == KIND_UNUSED ||
              (e.kind == KIND_LOAD_BYTE && e.load_index >= PAYLOAD_BYTES_DEF) ||
              ((e.kind == KIND_RX_DONE || e.kind == KIND_TX_DONE) && lookahead.phase == PH_IDLE)))
            counted_events++;
        void'(lookahead.sequence_event(e));
    endtask

    task automatic offer_kind(logic [2:0] kind);
        offer_event(random_event(kind));
    endtask

    // Feed SPI done events until the sequencer is idle again. The two threads
    // report in random order; each reports once per phase in the well-formed
    // case. Now and then slip in noise, a payload load just ahead of the byte
    // about to go out, or a surplus FIFO byte. With may_abort set the sequence
    // is sometimes left half done, so the next start is refused.
    task automatic finish_phases(bit may_abort);
        req_t       e;
        int         budget;
        logic [2:0] first_thread;
        budget       = -1;
        first_thread = KIND_TX_DONE;
        if (may_abort && $urandom_range(9) == 0)
            budget = $urandom_range(6, 1);
        while (lookahead.phase != PH_IDLE && budget != 0)
        begin
            if (budget > 0)
                budget--;
            if ($urandom_range(99) < 6)
                offer_kind(3'($urandom_range(7)));
            else if ((lookahead.phase == PH_WF_CMD || lookahead.phase == PH_WF_DAT) &&
                     lookahead.send_count < PAYLOAD_BYTES_DEF && $urandom_range(9) == 0)
            begin
                e = random_event(KIND_LOAD_BYTE);
                e.load_index = (lookahead.phase == PH_WF_CMD) ? 6'd0
                                                               : lookahead.send_count[5:0];
                offer_event(e);
            end
            else if (lookahead.phase == PH_RF_DAT || lookahead.phase == PH_WF_DAT)
            begin
                if (lookahead.recv_count < PAYLOAD_BYTES_DEF &&
                    (lookahead.send_count >= PAYLOAD_BYTES_DEF || $urandom_range(1) == 0))
                    offer_kind(KIND_RX_DONE);
                else if (lookahead.recv_count >= PAYLOAD_BYTES_DEF && $urandom_range(9) == 0)
                    offer_kind(KIND_RX_DONE);
                else
                    offer_kind(KIND_TX_DONE);
            end
            else if (lookahead.join_count == 2'd0)
            begin
                first_thread = ($urandom_range(1) == 0) ? KIND_RX_DONE : KIND_TX_DONE;
                offer_kind(first_thread);
            end
            else
                offer_kind((first_thread == KIND_RX_DONE) ? KIND_TX_DONE : KIND_RX_DONE);
        end
    endtask

    // Drop valid and wait until every beat offered has come back.
    task automatic settle();
        req_valid <= 1'b0;
        while (sb.results_checked != beats_sent)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_register(idx, data);
        lookahead.write_register(idx, data);
        @(posedge clk);
    endtask

    task automatic program_registers(logic [7:0] opmode, logic [7:0] rx_mode, logic [7:0] fifo);
        write_register(CFG_OPMODE_ADDR, opmode);
        write_register(CFG_RX_MODE_VALUE, rx_mode);
        write_register(CFG_FIFO_ADDR, fifo);
        cfg_write <= 1'b0;
    endtask

    // Mostly well-formed transfers with random content; the rest is noise.
    task automatic run_random_phase(int unsigned target);
        req_t        e;
        int unsigned start;
        int unsigned pick;
        start = counted_events;
        while (counted_events - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                offer_kind(3'($urandom_range(7)));
            else if (pick < 25)
            begin
                e = random_event(KIND_LOAD_BYTE);
                if ($urandom_range(4) != 0)
                    e.load_index = 6'($urandom_range(PAYLOAD_BYTES_DEF - 1));
                offer_event(e);
            end
            else if (pick < 45)
            begin
                offer_kind(KIND_READ_REG);
                finish_phases(1'b1);
            end
            else if (pick < 65)
            begin
                offer_kind(KIND_WRITE_REG);
                finish_phases(1'b1);
            end
            else if (pick < 82)
            begin
                offer_kind(KIND_SEND_PACKET);
                finish_phases(1'b1);
                // the radio usually confirms the transmission
                if ($urandom_range(4) != 0)
                    offer_kind(KIND_RADIO_DONE);
            end
            else
            begin
                offer_kind(KIND_RADIO_DONE);
                finish_phases(1'b1);
            end
        end
    endtask

    initial
    begin
        req_t e;
        sb         = new();
        lookahead  = new();
        beats_sent = 0;
        counted_events = 0;
        steady_run   = 1'b0;
        hold_request = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Initialise the whole payload store: it is not cleared by reset and a
        // send must never read an entry that was never loaded.
        for (int i = 0; i < PAYLOAD_BYTES_DEF; i++)
        begin
            e = random_event(KIND_LOAD_BYTE);
            e.load_index = 6'(i);
            if (i == 0)
                e.load_value = 8'h00;
            else if (i == PAYLOAD_BYTES_DEF - 1)
                e.load_value = 8'hFF;
            offer_event(e);
        end

        // Directed checks under the reset configuration.
        // SPI done events while idle, the unused kind, loads beyond the payload
        offer_kind(KIND_RX_DONE);
        offer_kind(KIND_TX_DONE);
        offer_kind(KIND_UNUSED);
        e = random_event(KIND_LOAD_BYTE);
        e.load_index = 6'h3F;
        offer_event(e);
        e.load_index = 6'(PAYLOAD_BYTES_DEF);
        offer_event(e);

        // register read at the top address returning all ones
        e = random_event(KIND_READ_REG);
        e.reg_addr = 7'h7F;
        offer_event(e);
        offer_kind(KIND_TX_DONE);
        offer_kind(KIND_RX_DONE);
        e = random_event(KIND_RX_DONE);
        e.rx_byte = 8'hFF;
        offer_event(e);
        offer_kind(KIND_TX_DONE);

        // register write at address zero, then every start while busy
        e = random_event(KIND_WRITE_REG);
        e.reg_addr  = 7'h00;
        e.reg_value = 8'hFF;
        offer_event(e);
        offer_kind(KIND_READ_REG);
        offer_kind(KIND_WRITE_REG);
        offer_kind(KIND_SEND_PACKET);
        offer_kind(KIND_RADIO_DONE);
        finish_phases(1'b0);

        // Random part in four register settings: extremes first, then random.
        // Hold off the receiver once early in the second setting, and keep both
        // sides free of idling through the third.
        for (int p = 0; p < 4; p++)
        begin
            finish_phases(1'b0);
            settle();
            case (p)
                0:       program_registers(8'h7F, 8'hFF, 8'h00);
                1:       program_registers(8'h80, 8'h00, 8'hFF);
                default: program_registers(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            if (p == 1)
                hold_request = 1'b1;
            steady_run = (p == 2);
            run_random_phase(PHASE_EVENTS);
        end
        steady_run = 1'b0;
        finish_phases(1'b0);
        settle();

        // allow for the pipeline depth; anything turning up now is a stray beat
        repeat (8) @(posedge clk);

        if (sb.pending_outcomes.size() != 0)
        begin
            sb.failures++;
            $error("%0d results never arrived", sb.pending_outcomes.size());
        end

        $display("Covered %0d events over four register settings: %0d register reads,",
                 beats_sent, sb.reads_done);
        $display("%0d FIFO packets received, %0d sends confirmed, %0d starts refused as busy.",
                 sb.packets_done, sb.sends_done, sb.refused);
        if (sb.failures == 0)
            $display("spi_radio_register_sequencer: match");
        else
            $display("spi_radio_register_sequencer: mismatch");
        $finish;
    end

endmodule
